// ===== rtl/core/glcm_hw_pkg.sv =====
// glcm_hw_pkg: shared widths, codes and controller/datapath handshake structs
// for the glcm homogeneity window unit; depends on nothing
package glcm_hw_pkg;

  localparam int LEVELS_DEFAULT = 16;
  localparam int FRAC_DEFAULT   = 16;

  localparam int IDX_W   = 4;
  localparam int GRAY_W  = 8;
  localparam int PROB_W  = 16;
  localparam int OUT_W   = 24;
  localparam int OUT_FRAC = 16;
  localparam int NUM_W   = PROB_W + OUT_FRAC;

  typedef enum logic [1:0] {
    FUNC_LABEL = 2'd0,
    FUNC_PROB  = 2'd1,
    FUNC_PIXEL = 2'd2
  } func_e;

  typedef struct packed {
    logic take_item;
    logic walk_init;
    logic advance;
    logic rd_en;
    logic div_start;
    logic accumulate;
    logic load_out;
  } glcm_hw_cmd_t;

  typedef struct packed {
    logic na;
    logic pair_hit;
    logic pair_end;
    logic div_done;
  } glcm_hw_stat_t;

endpackage

// ===== rtl/core/glcm_homogeneity_window_unit.sv =====
// glcm_homogeneity_window_unit: top level of the glcm homogeneity block
// uses glcm_hw_pkg, glcm_hw_ctrl, glcm_hw_datapath
//
// channel  direction  handshake                  payload
// in       input      in_valid_i / in_ready_o    func, row/col index, label, prob, pixel
// out      output     out_valid_o / out_ready_i  homogeneity, result_missing
// cfg      input      cfg_valid_i / cfg_ready_o  skip_missing
//
// loads and pixels are taken while idle; a last pixel giving NA skips the walk
// a scored window walks all N*N positions, one a cycle where the pair is absent;
// each of the P*P present pairs (P present levels) is read and divided on the one-bit-a-cycle divider
// input is held off during the walk; the result register lets the next item in
// while a result waits, a further last pixel waits for the output slot to free
// reset clears control state only; probability memory and labels need no clearing
module glcm_homogeneity_window_unit #(
  parameter int MAX_LEVELS     = glcm_hw_pkg::LEVELS_DEFAULT,
  parameter int PROB_FRAC_BITS = glcm_hw_pkg::FRAC_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_skip_missing_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [3:0]  row_index_i,
  input  logic [3:0]  col_index_i,
  input  logic [7:0]  label_value_i,
  input  logic [15:0] probability_i,
  input  logic [7:0]  pixel_value_i,
  input  logic        pixel_missing_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [23:0] homogeneity_o,
  output logic        result_missing_o
);
  import glcm_hw_pkg::*;

  glcm_hw_cmd_t  cmd;
  glcm_hw_stat_t stat;

  assign cfg_ready_o = 1'b1;

  glcm_hw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (func_i),
    .last_i     (last_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  glcm_hw_datapath #(
    .MAX_LEVELS    (MAX_LEVELS),
    .PROB_FRAC_BITS(PROB_FRAC_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_skip_missing_i(cfg_skip_missing_i),
    .func_i            (func_i),
    .row_index_i       (row_index_i),
    .col_index_i       (col_index_i),
    .label_value_i     (label_value_i),
    .probability_i     (probability_i),
    .pixel_value_i     (pixel_value_i),
    .pixel_missing_i   (pixel_missing_i),
    .homogeneity_o     (homogeneity_o),
    .result_missing_o  (result_missing_o)
  );

endmodule

// ===== rtl/core/glcm_hw_div.sv =====
// glcm_hw_div: restoring divider, one quotient bit per cycle
// stand-alone, no package needed
module glcm_hw_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int CW = $clog2(NUM_W);
  localparam logic [CW-1:0] CNT_LAST = CW'(NUM_W - 1);

  logic             busy_q, done_q;
  logic [CW-1:0]    cnt_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W:0]   shift, diff;
  logic             ge;

  assign shift = {rem_q, quo_q[NUM_W-1]};
  assign ge    = shift >= {1'b0, den_q};
  assign diff  = shift - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NUM_W-2:0], ge};
      rem_q <= ge ? diff[DEN_W-1:0] : shift[DEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

`ifndef SYNTH
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> rem_q < den_q) else $error("divider remainder not below divisor");
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider started while busy");
  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> den_i != '0) else $error("divider started with zero divisor");
`endif

endmodule

// ===== rtl/core/glcm_hw_datapath.sv =====
// glcm_hw_datapath: label slots, presence mask, probability memory, pair
// counters, divider and saturating accumulator; uses glcm_hw_pkg, glcm_hw_div
module glcm_hw_datapath #(
  parameter int MAX_LEVELS     = 16,
  parameter int PROB_FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  glcm_hw_pkg::glcm_hw_cmd_t     cmd_i,
  output glcm_hw_pkg::glcm_hw_stat_t    stat_o,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_skip_missing_i,
  input  logic [1:0]                    func_i,
  input  logic [3:0]                    row_index_i,
  input  logic [3:0]                    col_index_i,
  input  logic [7:0]                    label_value_i,
  input  logic [15:0]                   probability_i,
  input  logic [7:0]                    pixel_value_i,
  input  logic                          pixel_missing_i,
  output logic [23:0]                   homogeneity_o,
  output logic                          result_missing_o
);
  import glcm_hw_pkg::*;

  localparam int LW    = $clog2(MAX_LEVELS);
  localparam int DEPTH = MAX_LEVELS * MAX_LEVELS;
  localparam int AW    = $clog2(DEPTH);
  localparam int DEN_W = $clog2((MAX_LEVELS - 1) * (MAX_LEVELS - 1) + 2);
  localparam logic [LW-1:0] POS_LAST = LW'(MAX_LEVELS - 1);
  localparam logic [NUM_W:0] OUT_MAX = (NUM_W+1)'((1 << OUT_W) - 1);

  logic                  skip_q;
  logic [MAX_LEVELS-1:0] label_valid_q, present_q;
  logic                  saw_missing_q, saw_unmatched_q;
  logic [GRAY_W-1:0]     labels_q [MAX_LEVELS];
  logic [PROB_W-1:0]     prob_mem [DEPTH];
  logic [PROB_W-1:0]     rd_data_q;
  logic [LW-1:0]         j_q, k_q;
  logic [OUT_W-1:0]      acc_q;
  logic [OUT_W-1:0]      homog_q;
  logic                  res_na_q;

  logic [MAX_LEVELS-1:0] match, first_match_bit;
  logic                  row_ok, col_ok, na;
  logic [LW-1:0]         slot;
  logic [AW-1:0]         wr_addr, rd_addr;
  logic [LW-1:0]         pos_diff;
  logic [2*LW-1:0]       dist_sq;
  logic [2*LW:0]         den_full;
  logic [DEN_W-1:0]      den;
  logic [NUM_W-1:0]      num, quot;
  logic [NUM_W:0]        sum;
  logic                  div_done;

  // one comparator per slot, lowest matching slot wins
  always_comb begin
    for (int s = 0; s < MAX_LEVELS; s++) begin
      match[s] = label_valid_q[s] && (labels_q[s] == pixel_value_i);
    end
  end
  assign first_match_bit = match & (~match + 1'b1);

  assign row_ok  = 32'(row_index_i) < MAX_LEVELS;
  assign col_ok  = 32'(col_index_i) < MAX_LEVELS;
  assign slot    = LW'(row_index_i);
  assign wr_addr = AW'(32'(row_index_i) * MAX_LEVELS + 32'(col_index_i));
  assign rd_addr = AW'(32'(j_q) * MAX_LEVELS + 32'(k_q));

  assign na = (saw_missing_q && !skip_q) || saw_unmatched_q || (present_q == '0);

  // weight denominator 1 + d^2 for the current pair
  assign pos_diff = (j_q > k_q) ? (j_q - k_q) : (k_q - j_q);
  assign dist_sq  = pos_diff * pos_diff;
  assign den_full = {1'b0, dist_sq} + (2*LW+1)'(1);
  assign den      = den_full[DEN_W-1:0];
  assign num      = {rd_data_q, {OUT_FRAC{1'b0}}} >> PROB_FRAC_BITS;

  assign sum = (NUM_W+1)'(acc_q) + (NUM_W+1)'(quot);

  glcm_hw_div #(
    .NUM_W(NUM_W),
    .DEN_W(DEN_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (num),
    .den_i  (den),
    .done_o (div_done),
    .quot_o (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q          <= 1'b0;
      label_valid_q   <= '0;
      present_q       <= '0;
      saw_missing_q   <= 1'b0;
      saw_unmatched_q <= 1'b0;
      j_q             <= '0;
      k_q             <= '0;
      acc_q           <= '0;
    end else begin
      if (cfg_valid_i) begin
        skip_q <= cfg_skip_missing_i;
      end
      if (cmd_i.take_item) begin
        unique case (func_i)
          FUNC_LABEL: begin
            if (row_ok) begin
              label_valid_q[slot] <= 1'b1;
            end
          end
          FUNC_PIXEL: begin
            if (pixel_missing_i) begin
              saw_missing_q <= 1'b1;
            end else if (match != '0) begin
              present_q <= present_q | first_match_bit;
            end else begin
              saw_unmatched_q <= 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd_i.walk_init) begin
        j_q   <= '0;
        k_q   <= '0;
        acc_q <= '0;
      end
      if (cmd_i.advance) begin
        if (k_q == POS_LAST) begin
          k_q <= '0;
          j_q <= j_q + 1'b1;
        end else begin
          k_q <= k_q + 1'b1;
        end
      end
      if (cmd_i.accumulate) begin
        acc_q <= (sum > OUT_MAX) ? '1 : sum[OUT_W-1:0];
      end
      if (cmd_i.load_out) begin
        label_valid_q   <= '0;
        present_q       <= '0;
        saw_missing_q   <= 1'b0;
        saw_unmatched_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item && func_i == FUNC_LABEL && row_ok) begin
      labels_q[slot] <= label_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item && func_i == FUNC_PROB && row_ok && col_ok) begin
      prob_mem[wr_addr] <= probability_i;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= prob_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      homog_q  <= na ? '0 : acc_q;
      res_na_q <= na;
    end
  end

  assign stat_o.na       = na;
  assign stat_o.pair_hit = present_q[j_q] && present_q[k_q];
  assign stat_o.pair_end = (j_q == POS_LAST) && (k_q == POS_LAST);
  assign stat_o.div_done = div_done;

  assign homogeneity_o    = homog_q;
  assign result_missing_o = res_na_q;

endmodule

// ===== rtl/core/glcm_hw_ctrl.sv =====
// glcm_hw_ctrl: state machine sequencing item intake, the pair walk and
// the result register; uses glcm_hw_pkg
module glcm_hw_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 func_i,
  input  logic                       last_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  input  glcm_hw_pkg::glcm_hw_stat_t stat_i,
  output glcm_hw_pkg::glcm_hw_cmd_t  cmd_o
);
  import glcm_hw_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_READ,
    S_DIV,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.take_item = in_valid_i;
        if (in_valid_i && func_i == FUNC_PIXEL && last_i) begin
          state_d = S_START;
        end
      end
      S_START: begin
        cmd_o.walk_init = 1'b1;
        state_d = stat_i.na ? S_FINISH : S_SCAN;
      end
      S_SCAN: begin
        if (stat_i.pair_hit) begin
          cmd_o.rd_en = 1'b1;
          state_d = S_READ;
        end else begin
          cmd_o.advance = 1'b1;
          if (stat_i.pair_end) begin
            state_d = S_FINISH;
          end
        end
      end
      S_READ: begin
        cmd_o.div_start = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          cmd_o.accumulate = 1'b1;
          cmd_o.advance    = 1'b1;
          state_d = stat_i.pair_end ? S_FINISH : S_SCAN;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  a_finish_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && out_free) |=> (out_valid_q && state_q == S_IDLE))
    else $error("result not loaded on leaving finish");
`endif

endmodule
